// ----- rtl/hcbp_pkg.sv -----
package hcbp_pkg;

  localparam int CODE_W              = 32;
  localparam int LEN_W               = 6;
  localparam int SYM_W               = 8;
  localparam int MAX_CODE_BITS_DEF   = 32;
  localparam int SYMBOL_COUNT_DEF    = 256;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_FLUSH  = 2'd2
  } mode_t;

endpackage

// ----- rtl/huffman_code_bit_packer_unit.sv -----
// Table-driven Huffman code packer. A load request writes one code and its length
// (saturated to MAX_CODE_BITS, at most 32) into the table, an encode request looks
// up its symbol's code and appends it MSB-first to the bit packer, and a flush
// request returns the partial byte zero-padded on the right and clears the packer.
// Completed bytes leave one per cycle while out_stall is low, earliest bit in
// bit 7; last_of_run marks the final byte of each request. A new request is
// taken every cycle unless in_stall is high; an encode or flush that completes k
// bytes (k is at most 4 for an encode, 1 for a flush) holds the single-byte output
// port until its k bytes have left, so the sustained rate is one request per cycle
// or one byte per cycle, whichever is lower. The table is a single-port memory read
// at the accepting edge; the bytes are then registered in the output buffer.
// Encoding a symbol that was never loaded gives undefined bits.
module huffman_code_bit_packer_unit
  import hcbp_pkg::*;
#(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
  parameter int SYMBOL_COUNT  = SYMBOL_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_mode,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [CODE_W-1:0] in_code_bits,
  input  logic [LEN_W-1:0]  in_code_length,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_last_of_run
);

  localparam int LEN_LIMIT = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;
  localparam int ADDR_W    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  logic [CODE_W-1:0] code_mem [SYMBOL_COUNT];
  logic [LEN_W-1:0]  len_mem  [SYMBOL_COUNT];

  logic              in_accept;
  logic              in_sym_ok;
  logic [ADDR_W-1:0] in_addr;
  logic [LEN_W-1:0]  load_len;

  logic              s1_valid_r;
  mode_t             s1_mode_r;
  logic              s1_ok_r;
  logic [CODE_W-1:0] rd_code_r;
  logic [LEN_W-1:0]  rd_len_r;

  logic [7:0]        pend_bits_r, pend_bits_nxt;
  logic [2:0]        pend_cnt_r, pend_cnt_nxt;
  logic [31:0]       buf_r, buf_nxt;
  logic [2:0]        cnt_r, cnt_nxt;

  logic [LEN_W-1:0]  clen;
  logic [CODE_W-1:0] code_l;
  logic [39:0]       win;
  logic [LEN_W-1:0]  total;
  logic [2:0]        nbytes;
  logic [7:0]        left_byte;
  logic [2:0]        s1_bytes;
  logic              out_take;
  logic              buf_free;
  logic              s1_go;

  assign in_accept = in_valid && !in_stall;
  assign in_sym_ok = ({1'b0, in_symbol} < 9'(SYMBOL_COUNT));
  assign in_addr   = in_symbol[ADDR_W-1:0];
  assign load_len  = (in_code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT)
                                                            : in_code_length;

  // table write and registered read share the acceptance edge
  always_ff @(posedge clk) begin
    if (in_accept && in_sym_ok) begin
      if (mode_t'(in_mode) == MODE_LOAD) begin
        code_mem[in_addr] <= in_code_bits;
        len_mem[in_addr]  <= load_len;
      end
      rd_code_r <= code_mem[in_addr];
      rd_len_r  <= len_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_mode_r <= mode_t'(in_mode);
      s1_ok_r   <= in_sym_ok;
    end
  end

  // left-justify the code, then slot it in behind the pending bits
  always_comb begin
    clen   = (rd_len_r > LEN_W'(CODE_W)) ? LEN_W'(CODE_W) : rd_len_r;
    code_l = rd_code_r << (LEN_W'(CODE_W) - clen);
    win    = {pend_bits_r, 32'b0} | ({code_l, 8'b0} >> pend_cnt_r);
    total  = {3'b0, pend_cnt_r} + clen;
    nbytes = total[5:3];
    unique case (nbytes)
      3'd0:    left_byte = win[39:32];
      3'd1:    left_byte = win[31:24];
      3'd2:    left_byte = win[23:16];
      3'd3:    left_byte = win[15:8];
      default: left_byte = win[7:0];
    endcase
  end

  always_comb begin
    s1_bytes = 3'd0;
    if (s1_mode_r == MODE_ENCODE && s1_ok_r) begin
      s1_bytes = nbytes;
    end else if (s1_mode_r == MODE_FLUSH && pend_cnt_r != 3'd0) begin
      s1_bytes = 3'd1;
    end
  end

  assign out_take = out_valid && !out_stall;
  assign buf_free = (cnt_r == 3'd0) || (cnt_r == 3'd1 && out_take);
  assign s1_go    = s1_valid_r && (s1_bytes == 3'd0 || buf_free);
  assign in_stall = s1_valid_r && !s1_go;

  always_comb begin
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    buf_nxt       = buf_r;
    cnt_nxt       = cnt_r;
    if (out_take) begin
      buf_nxt = {buf_r[23:0], 8'b0};
      cnt_nxt = cnt_r - 3'd1;
    end
    if (s1_go) begin
      if (s1_mode_r == MODE_ENCODE && s1_ok_r) begin
        pend_bits_nxt = left_byte;
        pend_cnt_nxt  = total[2:0];
        if (s1_bytes != 3'd0) begin
          buf_nxt = win[39:8];
          cnt_nxt = s1_bytes;
        end
      end else if (s1_mode_r == MODE_FLUSH) begin
        pend_bits_nxt = 8'b0;
        pend_cnt_nxt  = 3'd0;
        if (s1_bytes != 3'd0) begin
          buf_nxt = {pend_bits_r, 24'b0};
          cnt_nxt = 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= 8'b0;
      pend_cnt_r  <= 3'd0;
      cnt_r       <= 3'd0;
    end else begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  assign out_valid       = (cnt_r != 3'd0);
  assign out_byte        = buf_r[31:24];
  assign out_last_of_run = (cnt_r == 3'd1);

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("output byte count out of range");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_bytes != 3'd0 && out_valid))
    else $error("input stalled without a blocked request");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_mode_r == MODE_FLUSH) |=> (pend_cnt_r == 3'd0 && pend_bits_r == 8'b0))
    else $error("flush did not clear the packer");

  a_flush_one_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_mode_r == MODE_FLUSH && pend_cnt_r != 3'd0) |=> (cnt_r == 3'd1))
    else $error("flush did not queue exactly one byte");
`endif

endmodule

// ----- tb/sv/huffman_code_bit_packer_unit_tb.sv -----
module huffman_code_bit_packer_unit_tb;
  import hcbp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int LEN_CAP = (MAX_CODE_BITS_DEF < 32) ? MAX_CODE_BITS_DEF : 32;
  localparam int RANDOM_REQUESTS = 135;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 16;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } packed_byte_t;

  typedef struct {
    logic [1:0]        mode;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    bit                typed;
    int                n_typed;
    logic [7:0]        tbyte;
  } step_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_mode;
  logic [SYM_W-1:0]  in_symbol;
  logic [CODE_W-1:0] in_code_bits;
  logic [LEN_W-1:0]  in_code_length;
  logic              out_valid;
  logic              out_stall;
  logic [7:0]        out_byte;
  logic              out_last_of_run;

  huffman_code_bit_packer_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_symbol       (in_symbol),
    .in_code_bits    (in_code_bits),
    .in_code_length  (in_code_length),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

  // own copy of the code table and bit packer
  logic [CODE_W-1:0] code_tbl [256];
  int                len_tbl [256];
  bit                loaded [256];
  int                loaded_syms [$];
  logic [7:0]        acc_bits;
  int                acc_count;

  packed_byte_t expected_bytes [$];
  packed_byte_t fresh_bytes [$];
  packed_byte_t got_exp;
  step_row_t    directed_rows [$];

  int errors;
  int idle_cycles;
  int stall_left;
  bit quiet;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic step_row_t mk_row(logic [1:0] m, logic [7:0] s, logic [31:0] c,
                                       logic [5:0] l, bit t, int n, logic [7:0] b);
    step_row_t r;
    r.mode = m;
    r.sym = s;
    r.code = c;
    r.len = l;
    r.typed = t;
    r.n_typed = n;
    r.tbyte = b;
    return r;
  endfunction

  function automatic void add_row(step_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic void add_fresh(packed_byte_t b);
    fresh_bytes.insert(fresh_bytes.size(), b);
  endfunction

  function automatic void add_expected(packed_byte_t b);
    expected_bytes.insert(expected_bytes.size(), b);
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // packs one request into fresh_bytes and advances the table and packer
  task automatic pack_request(input step_row_t r);
    int clen;
    int i;
    fresh_bytes.delete();
    case (r.mode)
      MODE_LOAD: begin
        clen = (int'(r.len) > LEN_CAP) ? LEN_CAP : int'(r.len);
        code_tbl[r.sym] = r.code;
        len_tbl[r.sym] = clen;
        if (!loaded[r.sym]) begin
          loaded[r.sym] = 1'b1;
          loaded_syms.insert(loaded_syms.size(), int'(r.sym));
        end
      end
      MODE_ENCODE: begin
        clen = len_tbl[r.sym];
        for (i = clen; i > 0; i--) begin
          acc_bits[7 - acc_count] = code_tbl[r.sym][i - 1];
          acc_count++;
          if (acc_count == 8) begin
            add_fresh('{value: acc_bits, last: 1'b0});
            acc_bits = 8'h00;
            acc_count = 0;
          end
        end
        if (fresh_bytes.size() > 0) fresh_bytes[fresh_bytes.size() - 1].last = 1'b1;
      end
      MODE_FLUSH: begin
        if (acc_count != 0) begin
          add_fresh('{value: acc_bits, last: 1'b1});
          acc_bits = 8'h00;
          acc_count = 0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_request(input step_row_t r);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= r.mode;
    in_symbol <= r.sym;
    in_code_bits <= r.code;
    in_code_length <= r.len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pack_request(r);
    if (r.typed) begin
      if (r.n_typed > 0) add_expected('{value: r.tbyte, last: 1'b1});
    end else begin
      foreach (fresh_bytes[i]) add_expected(fresh_bytes[i]);
    end
  endtask

  // result side: random stalls and field checks
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected result: out_byte %0h out_last_of_run %0b", out_byte,
                 out_last_of_run);
          errors++;
        end else begin
          got_exp = expected_bytes[0];
          expected_bytes.delete(0);
          if (out_byte !== got_exp.value) begin
            $error("out_byte: expected %0h actual %0h", got_exp.value, out_byte);
            errors++;
          end
          if (out_last_of_run !== got_exp.last) begin
            $error("out_last_of_run: expected %0b actual %0b", got_exp.last,
                   out_last_of_run);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0 && !quiet) begin
        stall_left <= pick_gap();
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles + 1 >= IDLE_LIMIT) begin
          $display("huffman_code_bit_packer_unit: mismatch");
          $finish;
        end
      end
    end
  end

  initial begin
    step_row_t r;
    int sent;
    int pick;
    bit drained;
    errors = 0;
    idle_cycles = 0;
    stall_left = 0;
    quiet = 1'b0;
    acc_bits = 8'h00;
    acc_count = 0;
    drained = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_mode <= MODE_LOAD;
    in_symbol <= '0;
    in_code_bits <= '0;
    in_code_length <= '0;
    out_stall <= 1'b0;

    // flush on an empty packer and the unused mode give nothing
    add_row(mk_row(MODE_FLUSH, 8'h00, 32'h0, 6'd0, 1'b1, 0, 8'h00));
    add_row(mk_row(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b1, 0, 8'h00));
    add_row(mk_row(MODE_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd8, 1'b1, 0, 8'h00));
    add_row(mk_row(MODE_ENCODE, 8'h00, 32'h0, 6'd0, 1'b1, 1, 8'hFF));
    // zero-length code at the top index
    add_row(mk_row(MODE_LOAD, 8'hFF, 32'h0, 6'd0, 1'b1, 0, 8'h00));
    add_row(mk_row(MODE_ENCODE, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b1, 0, 8'h00));
    // overlong length saturates to the code width
    add_row(mk_row(MODE_LOAD, 8'h01, 32'hFFFF_FFFF, 6'd63, 1'b1, 0, 8'h00));
    add_row(mk_row(MODE_ENCODE, 8'h01, 32'h0, 6'd0, 1'b0, 0, 8'h00));
    add_row(mk_row(MODE_LOAD, 8'h02, 32'h0000_0005, 6'd3, 1'b1, 0, 8'h00));
    add_row(mk_row(MODE_ENCODE, 8'h02, 32'h0, 6'd0, 1'b1, 0, 8'h00));
    add_row(mk_row(MODE_FLUSH, 8'h00, 32'h0, 6'd0, 1'b1, 1, 8'hA0));
    add_row(mk_row(MODE_FLUSH, 8'h00, 32'h0, 6'd0, 1'b1, 0, 8'h00));
    add_row(mk_row(MODE_LOAD, 8'h03, 32'hAAAA_AAAA, 6'd32, 1'b1, 0, 8'h00));
    add_row(mk_row(MODE_ENCODE, 8'h02, 32'h0, 6'd0, 1'b0, 0, 8'h00));
    add_row(mk_row(MODE_ENCODE, 8'h03, 32'h0, 6'd0, 1'b0, 0, 8'h00));
    add_row(mk_row(MODE_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0, 0, 8'h00));
    add_row(mk_row(MODE_LOAD, 8'h04, 32'h8000_0000, 6'd33, 1'b1, 0, 8'h00));
    add_row(mk_row(MODE_ENCODE, 8'h04, 32'h0, 6'd0, 1'b0, 0, 8'h00));
    add_row(mk_row(MODE_LOAD, 8'h05, 32'h0000_0001, 6'd1, 1'b1, 0, 8'h00));
    add_row(mk_row(MODE_ENCODE, 8'h05, 32'h0, 6'd0, 1'b0, 0, 8'h00));
    // unused mode mid-byte leaves the packer alone
    add_row(mk_row(MODE_UNUSED, 8'h05, 32'h0, 6'd0, 1'b1, 0, 8'h00));
    add_row(mk_row(MODE_ENCODE, 8'h00, 32'h0, 6'd0, 1'b0, 0, 8'h00));
    add_row(mk_row(MODE_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0, 0, 8'h00));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) send_request(directed_rows[i]);

    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      quiet = (sent >= 40 && sent < 70);
      if (sent == 110 && !drained) begin
        // hold off until the packer output has fully drained
        drained = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_bytes.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (loaded_syms.size() == 0) pick = 0;
      r = mk_row(MODE_UNUSED, 8'($urandom), $urandom, 6'($urandom), 1'b0, 0, 8'h00);
      if (pick < 18) begin
        r.mode = MODE_LOAD;
        if ($urandom_range(0, 99) < 70) r.len = 6'($urandom_range(1, 12));
        sent++;
      end else if (pick < 78) begin
        r.mode = MODE_ENCODE;
        r.sym = 8'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
        sent++;
      end else if (pick < 90) begin
        r.mode = MODE_FLUSH;
        sent++;
      end
      send_request(r);
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("huffman_code_bit_packer_unit: match");
    end else begin
      $display("huffman_code_bit_packer_unit: mismatch");
    end
    $finish;
  end

endmodule
